[hw/rtl/rmse_pkg.sv]
// shared types and constants for the row mse loss and gradient core
// no dependencies; imported by rmse_div and row_mse_loss_and_gradient_core

package rmse_pkg;

  // fixed field widths
  localparam int DATA_WIDTH = 16;
  localparam int ROW_LEN_W  = 11;
  localparam int LOSS_W     = 32;
  localparam int SUM_W      = 44;
  localparam int PROD_W     = 32;

  // divider sequencing, one quotient bit per step
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // request codes
  localparam logic FUNC_FWD = 1'b0;
  localparam logic FUNC_BWD = 1'b1;

  // result codes
  localparam logic KIND_LOSS = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/rmse_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on rmse_pkg; used by row_mse_loss_and_gradient_core

module rmse_div import rmse_pkg::*; #(
  parameter int LEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output div_status_t      status
);

  logic [SUM_W-1:0]     quo;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [LEN_W:0]       trial;
  logic                 ge;
  logic [LEN_W:0]       diff;

  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    ge    = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[SUM_W-2:0], ge};
        rem <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[hw/rtl/row_mse_loss_and_gradient_core.sv]
// row mse loss and gradient core: top level, sequencer and datapath
// depends on rmse_pkg and rmse_div
//
// channel   dir  handshake            payload
// -------   ---  -------------------  ---------------------------------------------
// in        in   in_valid / in_stall  func, predicted, target, upstream_grad,
//                                     prior_grad
// out       out  out_valid/out_stall  kind, row_loss, element_grad, saturated
// cfg       in   cfg_wr_en            cfg_wr_data (row_length)
//
// one request at a time: in_stall is high from acceptance until the sequencer
// returns to idle
// forward request that is not the last column of a row: accept, multiply,
// accumulate
// last forward column or backward request: accept, multiply, prepare, 44 divide
// steps of the shared divider, done, result
// the result sits in an output register; a stalled result holds the sequencer
// in its result state only if the next result is ready before it is taken
// reset is synchronous: row length goes to 1, column count and square sum to 0

module row_mse_loss_and_gradient_core import rmse_pkg::*; #(
  parameter int MAX_COLS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic signed [DATA_WIDTH-1:0] predicted,
  input  logic signed [DATA_WIDTH-1:0] target,
  input  logic signed [DATA_WIDTH-1:0] upstream_grad,
  input  logic signed [DATA_WIDTH-1:0] prior_grad,
  // row length register
  input  logic                         cfg_wr_en,
  input  logic [ROW_LEN_W-1:0]         cfg_wr_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [LOSS_W-1:0]            row_loss,
  output logic signed [DATA_WIDTH-1:0] element_grad,
  output logic                         saturated
);

  // largest usable row length: capped by MAX_COLS and by the register width
  localparam int LenMaxReg = (1 << ROW_LEN_W) - 1;
  localparam int EffMax    = (MAX_COLS < LenMaxReg) ? MAX_COLS : LenMaxReg;
  localparam int LEN_W     = (EffMax > 1) ? $clog2(EffMax + 1) : 1;
  localparam int GW        = 28;   // gradient sum width, holds prior + term
  localparam int QG_W      = 26;   // gradient quotient stays below 2**25
  localparam int BW_W      = 34;   // 2*product plus rounding half

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_RESULT
  } state_t;

  state_t state;

  // configuration and row state
  logic [ROW_LEN_W-1:0] row_length;
  logic [LEN_W-1:0]     column_count;
  logic [SUM_W-1:0]     square_sum;

  // captured request
  logic                         func_r;
  logic [DATA_WIDTH-1:0]        op_a;     // |predicted - target|
  logic [DATA_WIDTH-1:0]        op_b;     // same, or |upstream_grad|
  logic                         neg;      // sign of the gradient term
  logic signed [DATA_WIDTH-1:0] prior_r;
  logic [PROD_W-1:0]            prod;

  // request side helpers
  logic                      in_acc;
  logic signed [DATA_WIDTH:0] diff;
  logic [DATA_WIDTH-1:0]     dmag;
  logic [DATA_WIDTH-1:0]     umag;

  // effective row length: zero reads as one, clamp at the max
  logic [LEN_W-1:0] len;

  // accumulate and divide
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [LEN_W:0]   count_inc;
  logic             row_end;
  logic [BW_W-1:0]  bwd_num;
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [SUM_W-1:0] quotient;
  div_status_t      div_stat;

  // result formation
  logic                  fwd_sat;
  logic [LOSS_W-1:0]     loss_val;
  logic [QG_W-1:0]       qg;
  logic signed [GW-1:0]  term;
  logic signed [GW-1:0]  gsum;
  logic                  grad_sat;
  logic [DATA_WIDTH-1:0] grad_val;
  logic                  out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    diff = {predicted[DATA_WIDTH-1], predicted} - {target[DATA_WIDTH-1], target};
    dmag = diff[DATA_WIDTH] ? DATA_WIDTH'(-diff) : diff[DATA_WIDTH-1:0];
    umag = upstream_grad[DATA_WIDTH-1] ? DATA_WIDTH'(-upstream_grad)
                                       : DATA_WIDTH'(upstream_grad);
  end

  always_comb begin
    if (row_length == '0) begin
      len = LEN_W'(1);
    end else if (row_length > ROW_LEN_W'(EffMax)) begin
      len = LEN_W'(EffMax);
    end else begin
      len = LEN_W'(row_length);
    end
  end

  // forward accumulate with sticky saturation, backward rounding numerator
  always_comb begin
    sum_add      = {1'b0, square_sum} + (SUM_W + 1)'(prod);
    sum_sat      = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    count_inc    = {1'b0, column_count} + 1'b1;
    row_end      = (count_inc >= {1'b0, len});
    // floor(x / (256*len)) == floor(floor(x / 256) / len)
    bwd_num      = {1'b0, prod, 1'b0} + (BW_W'(len) << 7);
    div_start    = (state == ST_PREP) && ((func_r == FUNC_BWD) || row_end);
    div_dividend = (func_r == FUNC_BWD) ? SUM_W'(bwd_num[BW_W-1:8]) : sum_sat;
  end

  rmse_div #(
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (len),
    .quotient (quotient),
    .status   (div_stat)
  );

  always_comb begin
    fwd_sat  = |quotient[SUM_W-1:LOSS_W];
    loss_val = fwd_sat ? {LOSS_W{1'b1}} : quotient[LOSS_W-1:0];
    qg       = quotient[QG_W-1:0];
    term     = neg ? -$signed(GW'(qg)) : $signed(GW'(qg));
    gsum     = GW'(prior_r) + term;
    // out of range when the bits above the sign do not all match it
    grad_sat = (gsum[GW-1:DATA_WIDTH-1] != '0) && (gsum[GW-1:DATA_WIDTH-1] != '1);
    if (!grad_sat) begin
      grad_val = gsum[DATA_WIDTH-1:0];
    end else if (gsum[GW-1]) begin
      grad_val = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      grad_val = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row_length   <= ROW_LEN_W'(1);
      column_count <= '0;
      square_sum   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        row_length <= cfg_wr_data;
      end
      // the result state reloads the output register itself
      if (out_valid && !out_stall && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            func_r  <= func;
            op_a    <= dmag;
            op_b    <= (func == FUNC_BWD) ? umag : dmag;
            neg     <= upstream_grad[DATA_WIDTH-1] ^ diff[DATA_WIDTH];
            prior_r <= prior_grad;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(op_a * op_b);
          state <= ST_PREP;
        end
        ST_PREP: begin
          if (func_r == FUNC_BWD) begin
            state <= ST_DIV;
          end else if (row_end) begin
            // divider took the final sum; start the next row clean
            column_count <= '0;
            square_sum   <= '0;
            state        <= ST_DIV;
          end else begin
            column_count <= count_inc[LEN_W-1:0];
            square_sum   <= sum_sat;
            state        <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (func_r == FUNC_BWD) begin
              kind         <= KIND_GRAD;
              row_loss     <= '0;
              element_grad <= grad_val;
              saturated    <= grad_sat;
            end else begin
              kind         <= KIND_LOSS;
              row_loss     <= loss_val;
              element_grad <= '0;
              saturated    <= fwd_sat;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the divider is never restarted while it is still iterating
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a new result only ever comes out of the result state
  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESULT)
    else $error("result presented outside result state");

  // the field that does not belong to the result kind reads zero
  a_unused_field_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_LOSS) && (element_grad == '0)) ||
                  ((kind == KIND_GRAD) && (row_loss == '0)))
    else $error("unused result field not zero");
`endif

endmodule
